// ===== rtl/core/hsr_pkg.sv =====
`timescale 1ns / 1ps

package hsr_pkg;

  localparam int unsigned Q_W       = 28;
  localparam int unsigned DIFF_W    = 29;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned OFF_W     = 22;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned LO_W      = 15;
  localparam int unsigned MUL_OP_W  = 16;
  localparam int unsigned PROD_W    = Q_W + MUL_OP_W;
  localparam int unsigned ROW_ALIGN = 15;

  localparam logic [COLOR_W-1:0] FILL_COLOR = 32'hAAFF1144;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_PLACE
  } bk_state_e;

  // one decoded item as it sits in the queue
  typedef struct packed {
    op_e                      op;
    logic signed [Q_W-1:0]    left_x;
    logic signed [DIFF_W-1:0] left_diff;
    logic signed [Q_W-1:0]    left_slope;
    logic signed [Q_W-1:0]    right_x;
    logic signed [DIFF_W-1:0] right_diff;
    logic signed [Q_W-1:0]    right_slope;
    logic [ROW_W-1:0]         first_row;
    logic [ROW_W-1:0]         stop_row;
    logic [OFF_W-1:0]         row_base;
  } entry_t;

endpackage

// ===== rtl/core/hsr_front.sv =====
`timescale 1ns / 1ps

module hsr_front #(
  parameter int unsigned PITCH = 5120
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      left_x_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      left_y_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      left_slope_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      right_x_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      right_y_i,
  input  logic signed [hsr_pkg::Q_W-1:0]      right_slope_i,
  input  logic [hsr_pkg::ROW_W-1:0]           first_row_i,
  input  logic [hsr_pkg::ROW_W-1:0]           stop_row_i,
  output logic                                head_valid_o,
  output hsr_pkg::entry_t                     head_o,
  input  logic                                pop_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hsr_pkg::entry_t            fifo_q [DEPTH];
  hsr_pkg::entry_t            entry;
  logic [PTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       push;
  logic                       pop;
  logic signed [hsr_pkg::DIFF_W-1:0] row_fix;
  logic [hsr_pkg::ROW_W+hsr_pkg::OFF_W-1:0] base_full;

  // row in Q.16, then distance from each edge point
  assign row_fix   = $signed({{(hsr_pkg::DIFF_W - hsr_pkg::ROW_W - hsr_pkg::FRAC_W){1'b0}},
                              first_row_i, {hsr_pkg::FRAC_W{1'b0}}});
  assign base_full = (hsr_pkg::ROW_W + hsr_pkg::OFF_W)'(first_row_i) *
                     (hsr_pkg::ROW_W + hsr_pkg::OFF_W)'(PITCH);

  always_comb begin
    entry.op          = hsr_pkg::op_e'(operation_i);
    entry.left_x      = left_x_i;
    entry.left_diff   = row_fix - hsr_pkg::DIFF_W'(left_y_i);
    entry.left_slope  = left_slope_i;
    entry.right_x     = right_x_i;
    entry.right_diff  = row_fix - hsr_pkg::DIFF_W'(right_y_i);
    entry.right_slope = right_slope_i;
    entry.first_row   = first_row_i;
    entry.stop_row    = stop_row_i;
    entry.row_base    = base_full[hsr_pkg::OFF_W-1:0];
  end

  assign in_stall_o   = (count_q == CNT_W'(DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/core/hsr_back.sv =====
`timescale 1ns / 1ps

module hsr_back #(
  parameter int unsigned FRAME_WIDTH     = 1280,
  parameter int unsigned FRAME_HEIGHT    = 720,
  parameter int unsigned BYTES_PER_PIXEL = 4,
  parameter int unsigned PITCH           = 5120
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  hsr_pkg::entry_t                   head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              pixel_valid_o,
  output logic [hsr_pkg::OFF_W-1:0]         pixel_offset_o,
  output logic [hsr_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                              done_res_o
);

  localparam int unsigned COL_W  = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned CEIL_W = hsr_pkg::Q_W - hsr_pkg::FRAC_W + 1;
  localparam int unsigned FULL_W = hsr_pkg::PROD_W + hsr_pkg::LO_W + 1;
  localparam int unsigned SUM_W  = FULL_W - hsr_pkg::FRAC_W + 1;
  localparam int unsigned HI_W   = hsr_pkg::DIFF_W - hsr_pkg::LO_W;

  localparam logic signed [hsr_pkg::Q_W-1:0] Q_MAX = {1'b0, {(hsr_pkg::Q_W-1){1'b1}}};
  localparam logic signed [hsr_pkg::Q_W-1:0] Q_MIN = {1'b1, {(hsr_pkg::Q_W-1){1'b0}}};

  function automatic logic signed [hsr_pkg::Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [hsr_pkg::Q_W-1:0] r;
    if (v > SUM_W'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < SUM_W'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[hsr_pkg::Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clip_col(input logic signed [hsr_pkg::Q_W-1:0] e);
    logic signed [hsr_pkg::Q_W:0] up;
    logic signed [CEIL_W-1:0]     c;
    logic [COL_W-1:0]             r;
    up = (hsr_pkg::Q_W+1)'(e) + (hsr_pkg::Q_W+1)'((1 << hsr_pkg::FRAC_W) - 1);
    c  = up[hsr_pkg::Q_W:hsr_pkg::FRAC_W];
    if (c < 0) begin
      r = '0;
    end else if (c > $signed(CEIL_W'(FRAME_WIDTH))) begin
      r = COL_W'(FRAME_WIDTH);
    end else begin
      r = c[COL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [hsr_pkg::Q_W-1:0] advance(
    input logic signed [hsr_pkg::Q_W-1:0] e,
    input logic signed [hsr_pkg::Q_W-1:0] s
  );
    logic signed [hsr_pkg::Q_W:0] sum;
    logic signed [hsr_pkg::Q_W-1:0] r;
    sum = (hsr_pkg::Q_W+1)'(e) + (hsr_pkg::Q_W+1)'(s);
    if (sum[hsr_pkg::Q_W] != sum[hsr_pkg::Q_W-1]) begin
      r = sum[hsr_pkg::Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r = sum[hsr_pkg::Q_W-1:0];
    end
    return r;
  endfunction

  hsr_pkg::bk_state_e state_q, state_d;

  logic signed [hsr_pkg::Q_W-1:0] left_edge_q, left_edge_d;
  logic signed [hsr_pkg::Q_W-1:0] right_edge_q, right_edge_d;
  logic signed [hsr_pkg::Q_W-1:0] left_step_q, left_step_d;
  logic signed [hsr_pkg::Q_W-1:0] right_step_q, right_step_d;
  logic [hsr_pkg::ROW_W-1:0]      current_row_q, current_row_d;
  logic [hsr_pkg::ROW_W-1:0]      end_row_q, end_row_d;
  logic [hsr_pkg::OFF_W-1:0]      row_base_q, row_base_d;
  logic [COL_W-1:0]               current_column_q, current_column_d;
  logic [COL_W-1:0]               span_end_column_q, span_end_column_d;
  logic                           span_loaded_q, span_loaded_d;
  logic                           active_q, active_d;

  logic signed [hsr_pkg::PROD_W-1:0] lp_lo_q, lp_hi_q, rp_lo_q, rp_hi_q;
  logic signed [hsr_pkg::MUL_OP_W-1:0] lmul_op, rmul_op;
  logic signed [hsr_pkg::PROD_W-1:0]   lprod, rprod;
  logic signed [FULL_W-1:0]            lfull, rfull;
  logic signed [SUM_W-1:0]             lsum, rsum;

  logic                          out_valid_q;
  logic                          pix_valid_q, pix_valid_d;
  logic [hsr_pkg::OFF_W-1:0]     pix_offset_q, pix_offset_d;
  logic                          done_q, done_d;
  logic                          emit;
  logic                          out_free;

  logic [COL_W-1:0]              col_cur, col_end, col_next;
  logic [hsr_pkg::ROW_W-1:0]     row_next;
  logic [hsr_pkg::OFF_W-1:0]     col_bytes;

  assign out_free = !out_valid_q || !out_stall_i;

  // one shared 28x16 multiplier per edge, low then high half of the distance
  always_comb begin
    if (state_q == hsr_pkg::BK_MUL_LO) begin
      lmul_op = $signed({1'b0, head_i.left_diff[hsr_pkg::LO_W-1:0]});
      rmul_op = $signed({1'b0, head_i.right_diff[hsr_pkg::LO_W-1:0]});
    end else begin
      lmul_op = hsr_pkg::MUL_OP_W'($signed(head_i.left_diff[hsr_pkg::DIFF_W-1 -: HI_W]));
      rmul_op = hsr_pkg::MUL_OP_W'($signed(head_i.right_diff[hsr_pkg::DIFF_W-1 -: HI_W]));
    end
  end

  assign lprod = hsr_pkg::PROD_W'(head_i.left_slope) * hsr_pkg::PROD_W'(lmul_op);
  assign rprod = hsr_pkg::PROD_W'(head_i.right_slope) * hsr_pkg::PROD_W'(rmul_op);

  assign lfull = (FULL_W'(lp_hi_q) <<< hsr_pkg::LO_W) + FULL_W'(lp_lo_q);
  assign rfull = (FULL_W'(rp_hi_q) <<< hsr_pkg::LO_W) + FULL_W'(rp_lo_q);
  assign lsum  = SUM_W'($signed(lfull[FULL_W-1:hsr_pkg::FRAC_W])) + SUM_W'(head_i.left_x);
  assign rsum  = SUM_W'($signed(rfull[FULL_W-1:hsr_pkg::FRAC_W])) + SUM_W'(head_i.right_x);

  always_comb begin
    state_d           = state_q;
    left_edge_d       = left_edge_q;
    right_edge_d      = right_edge_q;
    left_step_d       = left_step_q;
    right_step_d      = right_step_q;
    current_row_d     = current_row_q;
    end_row_d         = end_row_q;
    row_base_d        = row_base_q;
    current_column_d  = current_column_q;
    span_end_column_d = span_end_column_q;
    span_loaded_d     = span_loaded_q;
    active_d          = active_q;
    pix_valid_d       = 1'b0;
    pix_offset_d      = '0;
    done_d            = 1'b0;
    emit              = 1'b0;
    pop_o             = 1'b0;
    col_cur           = span_loaded_q ? current_column_q : clip_col(left_edge_q);
    col_end           = span_loaded_q ? span_end_column_q : clip_col(right_edge_q);
    col_next          = col_cur;
    row_next          = current_row_q + hsr_pkg::ROW_W'(1);
    col_bytes         = hsr_pkg::OFF_W'(col_cur) * hsr_pkg::OFF_W'(BYTES_PER_PIXEL);

    case (state_q)
      hsr_pkg::BK_RUN: begin
        if (head_valid_i && out_free) begin
          if (head_i.op == hsr_pkg::OP_START) begin
            state_d = hsr_pkg::BK_MUL_LO;
          end else begin
            emit  = 1'b1;
            pop_o = 1'b1;
            if (!active_q) begin
              done_d = 1'b1;
            end else if (current_row_q >= end_row_q ||
                         current_row_q >= hsr_pkg::ROW_W'(FRAME_HEIGHT)) begin
              active_d      = 1'b0;
              span_loaded_d = 1'b0;
              done_d        = 1'b1;
            end else begin
              if (col_cur < col_end) begin
                pix_valid_d  = 1'b1;
                pix_offset_d = row_base_q + col_bytes;
                col_next     = col_cur + COL_W'(1);
              end
              current_column_d  = col_next;
              span_end_column_d = col_end;
              span_loaded_d     = 1'b1;
              if (col_next >= col_end) begin
                left_edge_d   = advance(left_edge_q, left_step_q);
                right_edge_d  = advance(right_edge_q, right_step_q);
                current_row_d = row_next;
                row_base_d    = row_base_q + hsr_pkg::OFF_W'(PITCH);
                span_loaded_d = 1'b0;
                if (row_next >= end_row_q || row_next >= hsr_pkg::ROW_W'(FRAME_HEIGHT)) begin
                  active_d = 1'b0;
                  done_d   = 1'b1;
                end
              end
            end
          end
        end
      end
      hsr_pkg::BK_MUL_LO: begin
        state_d = hsr_pkg::BK_MUL_HI;
      end
      hsr_pkg::BK_MUL_HI: begin
        state_d = hsr_pkg::BK_PLACE;
      end
      hsr_pkg::BK_PLACE: begin
        if (out_free) begin
          emit              = 1'b1;
          pop_o             = 1'b1;
          state_d           = hsr_pkg::BK_RUN;
          left_step_d       = head_i.left_slope;
          right_step_d      = head_i.right_slope;
          left_edge_d       = sat_q(lsum);
          right_edge_d      = sat_q(rsum);
          current_row_d     = head_i.first_row;
          end_row_d         = head_i.stop_row;
          row_base_d        = head_i.row_base;
          current_column_d  = '0;
          span_end_column_d = '0;
          span_loaded_d     = 1'b0;
          active_d          = 1'b1;
        end
      end
      default: begin
        state_d = hsr_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= hsr_pkg::BK_RUN;
      left_edge_q       <= '0;
      right_edge_q      <= '0;
      left_step_q       <= '0;
      right_step_q      <= '0;
      current_row_q     <= '0;
      end_row_q         <= '0;
      row_base_q        <= '0;
      current_column_q  <= '0;
      span_end_column_q <= '0;
      span_loaded_q     <= 1'b0;
      active_q          <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      state_q           <= state_d;
      left_edge_q       <= left_edge_d;
      right_edge_q      <= right_edge_d;
      left_step_q       <= left_step_d;
      right_step_q      <= right_step_d;
      current_row_q     <= current_row_d;
      end_row_q         <= end_row_d;
      row_base_q        <= row_base_d;
      current_column_q  <= current_column_d;
      span_end_column_q <= span_end_column_d;
      span_loaded_q     <= span_loaded_d;
      active_q          <= active_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hsr_pkg::BK_MUL_LO) begin
      lp_lo_q <= lprod;
      rp_lo_q <= rprod;
    end
    if (state_q == hsr_pkg::BK_MUL_HI) begin
      lp_hi_q <= lprod;
      rp_hi_q <= rprod;
    end
    if (emit) begin
      pix_valid_q  <= pix_valid_d;
      pix_offset_q <= pix_offset_d;
      done_q       <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_valid_o  = pix_valid_q;
  assign pixel_offset_o = pix_offset_q;
  assign pixel_color_o  = hsr_pkg::FILL_COLOR;
  assign done_res_o     = done_q;

endmodule

// ===== rtl/core/half_triangle_span_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// channel | handshake               | payload
// input   | in_valid_i / in_stall_o  | operation, edge points, slopes, row range
// output  | out_valid_o / out_stall_i| pixel_valid, pixel_offset, pixel_color, done_res
//
// steps are handled by the executor in BK_RUN and sustain one transfer per clock while the output is not stalled
// a start goes through two passes of the edge multipliers (BK_MUL_LO, BK_MUL_HI), then placement (BK_PLACE)
// a two-entry queue registers the decoded inputs and absorbs output stalls
// reset is asynchronous, active low, and leaves the unit idle with an empty queue

module half_triangle_span_rasterizer_unit #(
  parameter int unsigned FRAME_WIDTH     = 1280,
  parameter int unsigned FRAME_HEIGHT    = 720,
  parameter int unsigned BYTES_PER_PIXEL = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [hsr_pkg::Q_W-1:0] left_x_i,
  input  logic signed [hsr_pkg::Q_W-1:0] left_y_i,
  input  logic signed [hsr_pkg::Q_W-1:0] left_slope_i,
  input  logic signed [hsr_pkg::Q_W-1:0] right_x_i,
  input  logic signed [hsr_pkg::Q_W-1:0] right_y_i,
  input  logic signed [hsr_pkg::Q_W-1:0] right_slope_i,
  input  logic [hsr_pkg::ROW_W-1:0]     first_row_i,
  input  logic [hsr_pkg::ROW_W-1:0]     stop_row_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pixel_valid_o,
  output logic [hsr_pkg::OFF_W-1:0]     pixel_offset_o,
  output logic [hsr_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          done_res_o
);

  localparam int unsigned PITCH =
    ((FRAME_WIDTH * BYTES_PER_PIXEL + hsr_pkg::ROW_ALIGN) / (hsr_pkg::ROW_ALIGN + 1)) *
    (hsr_pkg::ROW_ALIGN + 1);

  logic            head_valid;
  hsr_pkg::entry_t head;
  logic            pop;

  hsr_front #(
    .PITCH (PITCH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .left_x_i      (left_x_i),
    .left_y_i      (left_y_i),
    .left_slope_i  (left_slope_i),
    .right_x_i     (right_x_i),
    .right_y_i     (right_y_i),
    .right_slope_i (right_slope_i),
    .first_row_i   (first_row_i),
    .stop_row_i    (stop_row_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  hsr_back #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .FRAME_HEIGHT    (FRAME_HEIGHT),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
    .PITCH           (PITCH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_offset_o (pixel_offset_o),
    .pixel_color_o  (pixel_color_o),
    .done_res_o     (done_res_o)
  );

endmodule
